>>> rtl/assert_macros.svh
// Assertion macros for the beat phase tracker RTL.
// Included by files that check their own logic; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/bpt_pkg.sv
// Shared types and constants of the beat phase tracker.
// No dependencies.
package bpt_pkg;

    localparam int TIME_BITS_DEF = 40;
    localparam int IVL_BITS      = 17;
    localparam int WEIGHT_BITS   = 16;
    localparam int LEVEL_BITS    = 16;
    localparam int PHASE_BITS    = 16;
    localparam int TALLY_BITS    = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    // 0.67 in Q0.16
    localparam logic [WEIGHT_BITS-1:0] FOLD_LOW = 16'd43909;

    localparam logic [LEVEL_BITS-1:0]  RST_THRESH   = 16'd164;
    localparam logic [IVL_BITS-1:0]    RST_MIN_IVL  = 17'd16384;
    localparam logic [IVL_BITS-1:0]    RST_MAX_IVL  = 17'd98304;
    localparam logic [IVL_BITS-1:0]    RST_GAP      = 17'd49152;
    localparam logic [IVL_BITS-1:0]    RST_INIT_IVL = 17'd32768;
    localparam logic [WEIGHT_BITS-1:0] RST_FAST_W   = 16'd27525;
    localparam logic [WEIGHT_BITS-1:0] RST_SLOW_W   = 16'd13107;
    localparam logic [TALLY_BITS-1:0]  RST_WARMUP   = 4'd4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESH   = 3'd0,
        CFG_MIN_IVL  = 3'd1,
        CFG_MAX_IVL  = 3'd2,
        CFG_GAP      = 3'd3,
        CFG_INIT_IVL = 3'd4,
        CFG_FAST_W   = 3'd5,
        CFG_SLOW_W   = 3'd6,
        CFG_WARMUP   = 3'd7
    } bpt_cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARM,
        S_ONSET,
        S_FOLD_MUL,
        S_FOLD_UP,
        S_FOLD_DN,
        S_BLEND_A,
        S_BLEND_B,
        S_DIV,
        S_WAIT,
        S_DONE
    } bpt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bpt_div_stat_t;

endpackage

>>> rtl/bpt_if.sv
// Valid/ready channel interfaces of the beat phase tracker.
// Depends on bpt_pkg.
interface bpt_sample_if #(parameter int TIME_BITS = bpt_pkg::TIME_BITS_DEF) ();
    import bpt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TIME_BITS-1:0]  time_stamp;
    logic                  onset_seen;
    logic [LEVEL_BITS-1:0] onset_level;

    modport source (output valid, output time_stamp, output onset_seen,
                    output onset_level, input ready);
    modport sink   (input valid, input time_stamp, input onset_seen,
                    input onset_level, output ready);
endinterface

interface bpt_phase_if ();
    import bpt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PHASE_BITS-1:0] beat_phase;

    modport source (output valid, output beat_phase, input ready);
    modport sink   (input valid, input beat_phase, output ready);
endinterface

interface bpt_cfg_if ();
    import bpt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/beat_phase_tracker.sv
// Beat phase tracker top level: re-arm, onset pairing, octave fold, blend, phase.
// Depends on bpt_pkg, bpt_if, bpt_divider and assert_macros.svh.
//
// Usage:
//   sample : sink channel; one transaction per analysis frame carrying
//            time_stamp (Q24.16 s), onset_seen and onset_level (Q4.12).
//   phase  : source channel; one transaction per sample, beat_phase in Q0.16.
//   cfg    : register write channel, always ready; write only while idle.
// Per sample: arm check, onset check, then the bit-serial divider; an onset
//   pair that updates the interval first adds the fold multiply, the fold-up
//   and fold-down steps, the blend multiply and the blend update. The divider
//   gives one quotient bit per cycle over the time difference and the 16 fraction bits.
// Throughput: one sample at a time; sample.ready is high only when idle.
// The phase output is registered: a new sample is taken while a result waits,
//   and a finished result waits in the final step until phase.ready frees it.
// Reset: configuration and tracker state registers return to their default
//   values, the tracker is disarmed, no result is pending.
module beat_phase_tracker #(
    parameter int TIME_BITS = bpt_pkg::TIME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    bpt_sample_if.sink   sample,
    bpt_phase_if.source  phase,
    bpt_cfg_if.sink      cfg
);
    import bpt_pkg::*;

    `include "assert_macros.svh"

    localparam int LIM_BITS  = IVL_BITS + WEIGHT_BITS;
    localparam int PROD_BITS = 2 * IVL_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam logic [IVL_BITS-1:0] W_ONE      = IVL_BITS'(1 << WEIGHT_BITS);
    localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1 << (WEIGHT_BITS - 1));

    // configuration
    logic [LEVEL_BITS-1:0]  thresh_reg;
    logic [IVL_BITS-1:0]    min_reg;
    logic [IVL_BITS-1:0]    max_reg;
    logic [IVL_BITS-1:0]    gap_reg;
    logic [IVL_BITS-1:0]    init_reg;
    logic [WEIGHT_BITS-1:0] fast_reg;
    logic [WEIGHT_BITS-1:0] slow_reg;
    logic [TALLY_BITS-1:0]  warm_reg;

    // tracker state
    bpt_state_t             state_reg, state_next;
    logic                   armed_reg, armed_next;
    logic                   known_reg, known_next;
    logic [IVL_BITS-1:0]    ivl_reg, ivl_next;
    logic [TIME_BITS-1:0]   anchor_reg, anchor_next;
    logic [TIME_BITS-1:0]   last_reg, last_next;
    logic [TIME_BITS-1:0]   prior_reg, prior_next;
    logic [TALLY_BITS-1:0]  tally_reg, tally_next;
    logic                   out_valid_reg, out_valid_next;

    // per-sample working registers
    logic [TIME_BITS-1:0]   t_reg, t_next;
    logic                   seen_reg, seen_next;
    logic [LEVEL_BITS-1:0]  level_reg, level_next;
    logic [IVL_BITS-1:0]    f_reg, f_next;
    logic [LIM_BITS-1:0]    lim_reg, lim_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [PROD_BITS-1:0]   prod_reg, prod_next;
    logic [PHASE_BITS-1:0]  out_data_reg, out_data_next;

    logic                   rearm;
    logic [TIME_BITS-1:0]   step;
    logic [TIME_BITS-1:0]   obs;
    logic                   obs_ok;
    logic                   up_ok;
    logic                   dn_ok;
    logic [IVL_BITS+1:0]    ref3;
    logic [WEIGHT_BITS-1:0] w_sel;
    logic [IVL_BITS-1:0]    w_comp;
    logic [LIM_BITS-1:0]    fw;
    logic [SUM_BITS-1:0]    blend_sum;

    logic                   div_start;
    bpt_div_stat_t          div_stat;
    logic [PHASE_BITS-1:0]  div_q;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= RST_THRESH;
            min_reg    <= RST_MIN_IVL;
            max_reg    <= RST_MAX_IVL;
            gap_reg    <= RST_GAP;
            init_reg   <= RST_INIT_IVL;
            fast_reg   <= RST_FAST_W;
            slow_reg   <= RST_SLOW_W;
            warm_reg   <= RST_WARMUP;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_THRESH:   thresh_reg <= cfg.data[LEVEL_BITS-1:0];
                CFG_MIN_IVL:  min_reg    <= cfg.data[IVL_BITS-1:0];
                CFG_MAX_IVL:  max_reg    <= cfg.data[IVL_BITS-1:0];
                CFG_GAP:      gap_reg    <= cfg.data[IVL_BITS-1:0];
                CFG_INIT_IVL: init_reg   <= cfg.data[IVL_BITS-1:0];
                CFG_FAST_W:   fast_reg   <= cfg.data[WEIGHT_BITS-1:0];
                CFG_SLOW_W:   slow_reg   <= cfg.data[WEIGHT_BITS-1:0];
                CFG_WARMUP:   warm_reg   <= cfg.data[TALLY_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= 1'b0;
            known_reg     <= 1'b0;
            ivl_reg       <= RST_INIT_IVL;
            anchor_reg    <= '0;
            last_reg      <= '0;
            prior_reg     <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            known_reg     <= known_next;
            ivl_reg       <= ivl_next;
            anchor_reg    <= anchor_next;
            last_reg      <= last_next;
            prior_reg     <= prior_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        seen_reg     <= seen_next;
        level_reg    <= level_next;
        f_reg        <= f_next;
        lim_reg      <= lim_next;
        w_reg        <= w_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign step   = t_reg - prior_reg;
    assign rearm  = !armed_reg || (t_reg < prior_reg) || (step > TIME_BITS'(gap_reg));
    assign obs    = t_reg - last_reg;
    assign obs_ok = (t_reg >= last_reg) && (obs >= TIME_BITS'(min_reg))
                    && (obs <= TIME_BITS'(max_reg));

    assign up_ok  = (f_reg != '0) && ({f_reg, {WEIGHT_BITS{1'b0}}} < lim_reg)
                    && ({f_reg, 1'b0} <= {1'b0, max_reg});
    assign ref3   = {2'b00, ivl_reg} + {1'b0, ivl_reg, 1'b0};
    assign dn_ok  = ({1'b0, f_reg, 1'b0} > ref3) && ({1'b0, f_reg} >= {min_reg, 1'b0});

    assign w_sel     = (tally_reg < warm_reg) ? fast_reg : slow_reg;
    assign w_comp    = W_ONE - IVL_BITS'(w_sel);
    assign fw        = f_reg * w_reg;
    assign blend_sum = {1'b0, prod_reg} + SUM_BITS'(fw) + ROUND_HALF;

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        known_next     = known_reg;
        ivl_next       = ivl_reg;
        anchor_next    = anchor_reg;
        last_next      = last_reg;
        prior_next     = prior_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        seen_next      = seen_reg;
        level_next     = level_reg;
        f_next         = f_reg;
        lim_next       = lim_reg;
        w_next         = w_reg;
        prod_next      = prod_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        sample.ready   = (state_reg == S_IDLE);

        if (out_valid_reg && phase.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    t_next     = sample.time_stamp;
                    seen_next  = sample.onset_seen;
                    level_next = sample.onset_level;
                    state_next = S_ARM;
                end
            end
            S_ARM:
            begin
                if (rearm)
                begin
                    if (ivl_reg < min_reg || ivl_reg > max_reg)
                        ivl_next = init_reg;
                    armed_next  = 1'b1;
                    known_next  = 1'b0;
                    tally_next  = '0;
                    last_next   = '0;
                    anchor_next = t_reg;
                end
                prior_next = t_reg;
                state_next = S_ONSET;
            end
            S_ONSET:
            begin
                state_next = S_DIV;
                if (seen_reg && level_reg >= thresh_reg)
                begin
                    if (!known_reg)
                    begin
                        known_next  = 1'b1;
                        last_next   = t_reg;
                        anchor_next = t_reg;
                    end
                    else if (obs_ok)
                    begin
                        f_next     = obs[IVL_BITS-1:0];
                        state_next = S_FOLD_MUL;
                    end
                end
            end
            S_FOLD_MUL:
            begin
                lim_next   = ivl_reg * FOLD_LOW;
                state_next = S_FOLD_UP;
            end
            S_FOLD_UP:
            begin
                if (up_ok)
                    f_next = {f_reg[IVL_BITS-2:0], 1'b0};
                else
                    state_next = S_FOLD_DN;
            end
            S_FOLD_DN:
            begin
                if (dn_ok)
                    f_next = {1'b0, f_reg[IVL_BITS-1:1]};
                else
                    state_next = S_BLEND_A;
            end
            S_BLEND_A:
            begin
                w_next     = w_sel;
                prod_next  = ivl_reg * w_comp;
                state_next = S_BLEND_B;
            end
            S_BLEND_B:
            begin
                ivl_next = blend_sum[IVL_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
                if (tally_reg != '1)
                    tally_next = tally_reg + 1'b1;
                last_next   = t_reg;
                anchor_next = t_reg;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_stat.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || phase.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (ivl_reg == '0) ? '0 : div_q;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    bpt_divider #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (t_reg - anchor_reg),
        .divisor  (ivl_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign phase.valid      = out_valid_reg;
    assign phase.beat_phase = out_data_reg;

    `BPT_ASSERT_IMP(a_done_in_wait, clk, rst_n, div_stat.done, state_reg == S_WAIT)
    `BPT_ASSERT_NEXT(a_arm_sets, clk, rst_n, state_reg == S_ARM, armed_reg && prior_reg == t_reg)
    `BPT_ASSERT_NEXT(a_blend_tally, clk, rst_n, state_reg == S_BLEND_B, tally_reg != '0)
    `BPT_ASSERT_IMP(a_div_idle_start, clk, rst_n, div_start, !div_stat.busy)

endmodule

>>> rtl/bpt_divider.sv
// Bit-serial restoring divider: fraction of (dividend mod divisor) / divisor.
// Depends on bpt_pkg.
module bpt_divider #(
    parameter int TIME_BITS = bpt_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [TIME_BITS-1:0]          dividend,
    input  logic [bpt_pkg::IVL_BITS-1:0]  divisor,
    output bpt_pkg::bpt_div_stat_t        stat,
    output logic [bpt_pkg::PHASE_BITS-1:0] quotient
);
    import bpt_pkg::*;

    localparam int ITER     = TIME_BITS + PHASE_BITS;
    localparam int CNT_BITS = $clog2(ITER + 1);

    logic [TIME_BITS-1:0]  sh_reg;
    logic [IVL_BITS-1:0]   rem_reg;
    logic [PHASE_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [IVL_BITS:0]     trial;
    logic [IVL_BITS:0]     diff;
    logic                  fits;

    // dividend bits first, then zeros for the fraction
    assign trial = {rem_reg, sh_reg[TIME_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(ITER);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[TIME_BITS-2:0], 1'b0};
            rem_reg <= fits ? diff[IVL_BITS-1:0] : trial[IVL_BITS-1:0];
            quo_reg <= {quo_reg[PHASE_BITS-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
